>>> design/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and disabled
// while an active-low reset is asserted.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/stsd_pkg.sv
// -----------------------------------------------------------------------------
// stsd_pkg
// Types, constants and font tables of the scrolling text segment driver.
// -----------------------------------------------------------------------------
`default_nettype none

package stsd_pkg;

    localparam int TEXT_DEPTH  = 32;
    localparam int DIGITS      = 5;
    localparam int STORE_AW    = $clog2(TEXT_DEPTH);
    localparam int POS_W       = $clog2(TEXT_DEPTH + DIGITS) + 1;
    localparam int OP_W        = 3;
    localparam int INDEX_W     = 5;
    localparam int CODE_W      = 8;
    localparam int DIGIT_W     = 3;
    localparam int PATTERN_W   = 15;
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
    localparam logic [OP_W-1:0] OP_START = 3'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd4;

    localparam logic REG_ROW_SELECT = 1'b0;

    localparam logic signed [POS_W-1:0] POS_START = -1;
    localparam logic signed [POS_W-1:0] POS_WRAP  = -4;
    localparam logic [DIGIT_W-1:0]      LAST_DIGIT = DIGIT_W'(DIGITS - 1);

    localparam logic [CODE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CODE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CODE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CODE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CODE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CODE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CODE_W-1:0] CH_EQUALS  = 8'h3D;
    localparam logic [CODE_W-1:0] CH_MINUS   = 8'h2D;
    localparam int GLYPH_MINUS  = 26;
    localparam int GLYPH_EQUALS = 27;

    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_WRITE,
        CMD_START,
        CMD_TICK,
        CMD_STOP
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [INDEX_W-1:0]  index;
        logic [CODE_W-1:0]   code;
    } t_request;

    typedef struct packed {
        logic     valid;
        t_request req;
    } t_queue_head;

    localparam logic [PATTERN_W-1:0] LETTER_GLYPHS [2][28] = '{
        '{15'h4b19, 15'h5b42, 15'h0858, 15'h5a42, 15'h0859, 15'h0819, 15'h4958,
          15'h4319, 15'h1842, 15'h4250, 15'h2419, 15'h0058, 15'h461c, 15'h621c,
          15'h4a58, 15'h0b19, 15'h6a58, 15'h2b19, 15'h4949, 15'h1802, 15'h4258,
          15'h0438, 15'h6238, 15'h2424, 15'h1404, 15'h0c60, 15'h0101, 15'h0141},
        '{15'h4359, 15'h185b, 15'h4a40, 15'h185a, 15'h4b40, 15'h4340, 15'h4a49,
          15'h4319, 15'h1842, 15'h0a18, 15'h4324, 15'h4a00, 15'h6238, 15'h621c,
          15'h4a58, 15'h4351, 15'h4a5c, 15'h4355, 15'h4949, 15'h1042, 15'h4a18,
          15'h4620, 15'h461c, 15'h2424, 15'h2022, 15'h0c60, 15'h0101, 15'h0901}
    };

    localparam logic [PATTERN_W-1:0] DIGIT_GLYPHS [2][10] = '{
        '{15'h4a58, 15'h4200, 15'h0b51, 15'h4b41, 15'h4309, 15'h4949, 15'h4959,
          15'h4a00, 15'h4b59, 15'h4b49},
        '{15'h4a58, 15'h0018, 15'h0b51, 15'h0959, 15'h4119, 15'h4949, 15'h4b49,
          15'h0058, 15'h4b59, 15'h4959}
    };

    function automatic logic [PATTERN_W-1:0] glyph_of(input logic [CODE_W-1:0] ch,
                                                      input logic row);
        logic [CODE_W-1:0]    off;
        logic [PATTERN_W-1:0] g;
        off = '0;
        g   = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            off = ch - CH_UPPER_A;
            g   = LETTER_GLYPHS[row][off[4:0]];
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            off = ch - CH_LOWER_A;
            g   = LETTER_GLYPHS[row][off[4:0]];
        end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            off = ch - CH_ZERO;
            g   = DIGIT_GLYPHS[row][off[3:0]];
        end else if (ch == CH_EQUALS) begin
            g   = LETTER_GLYPHS[row][GLYPH_EQUALS];
        end else if (ch == CH_MINUS) begin
            g   = LETTER_GLYPHS[row][GLYPH_MINUS];
        end
        return g;
    endfunction

endpackage

`default_nettype wire

>>> design/stsd_front.sv
// -----------------------------------------------------------------------------
// stsd_front
// Request decoder and two-entry command queue feeding the frame engine.
// -----------------------------------------------------------------------------
`default_nettype none

module stsd_front
    import stsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [INDEX_W-1:0] i_index,
    input  wire logic [CODE_W-1:0]  i_code,
    output t_queue_head             o_head,
    input  wire logic               i_pop
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_request           r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    logic     keep;
    t_cmd     cmd;
    logic     push;

    always_comb begin
        keep = 1'b1;
        cmd  = CMD_CLEAR;
        unique case (i_op)
            OP_CLEAR: cmd = CMD_CLEAR;
            OP_WRITE: begin
                cmd  = CMD_WRITE;
                keep = (int'(i_index) < TEXT_DEPTH);
            end
            OP_START: cmd = CMD_START;
            OP_TICK:  cmd = CMD_TICK;
            OP_STOP:  cmd = CMD_STOP;
            default:  keep = 1'b0;
        endcase
    end

    assign o_ready          = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign push             = i_valid && o_ready && keep;
    assign o_head.valid     = (r_count != '0);
    assign o_head.req       = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_entry[r_wr_ptr] <= '{cmd: cmd, index: i_index, code: i_code};
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/stsd_back.sv
// -----------------------------------------------------------------------------
// stsd_back
// Text store, scroll state and digit sequencer with registered output stage.
// -----------------------------------------------------------------------------
`default_nettype none

module stsd_back
    import stsd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_queue_head           i_head,
    output logic                       o_pop,
    input  wire logic                  i_row_select,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DIGIT_W-1:0]         o_digit,
    output logic [PATTERN_W-1:0]       o_pattern,
    output logic                       o_last
);

    typedef enum logic {
        S_IDLE,
        S_FRAME
    } t_state;

    t_state                    r_state;
    logic [CODE_W-1:0]         r_data [TEXT_DEPTH];
    logic [TEXT_DEPTH-1:0]     r_valid;
    logic signed [POS_W-1:0]   r_pos;
    logic                      r_active;
    logic                      r_advance;
    logic [DIGIT_W-1:0]        r_digit;
    logic [CODE_W-1:0]         r_head_char;
    logic                      r_out_valid;
    logic [DIGIT_W-1:0]        r_out_digit;
    logic [PATTERN_W-1:0]      r_out_pattern;
    logic                      r_out_last;

    logic signed [POS_W-1:0]   addr_sum;
    logic                      in_range;
    logic [STORE_AW-1:0]       rd_idx;
    logic [STORE_AW-1:0]       wr_idx;
    logic [CODE_W-1:0]         ch;
    logic [PATTERN_W-1:0]      glyph;
    logic                      out_free;
    logic signed [POS_W-1:0]   n_pos;

    always_comb begin
        addr_sum = r_pos + POS_W'(r_digit);
        in_range = !addr_sum[POS_W-1] && ($unsigned(addr_sum) < POS_W'(TEXT_DEPTH));
        rd_idx   = addr_sum[STORE_AW-1:0];
        ch       = (in_range && r_valid[rd_idx]) ? r_data[rd_idx] : '0;
        glyph    = glyph_of(ch, i_row_select);
        wr_idx   = STORE_AW'(i_head.req.index);
        out_free = !r_out_valid || i_ready;
        o_pop    = (r_state == S_IDLE) && i_head.valid;
        priority if (r_pos[POS_W-1]) begin
            n_pos = r_pos + 1'b1;
        end else if (r_head_char == '0) begin
            n_pos = POS_WRAP;
        end else begin
            n_pos = r_pos + 1'b1;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_digit   = r_out_digit;
    assign o_pattern = r_out_pattern;
    assign o_last    = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pos       <= POS_START;
            r_active    <= 1'b0;
            r_advance   <= 1'b0;
            r_digit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_FRAME) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_head.req.cmd)
                            CMD_CLEAR: r_valid <= '0;
                            CMD_WRITE: begin
                                r_data[wr_idx]  <= i_head.req.code;
                                r_valid[wr_idx] <= 1'b1;
                            end
                            CMD_START: begin
                                r_pos     <= POS_START;
                                r_active  <= 1'b1;
                                r_advance <= 1'b0;
                                r_digit   <= '0;
                                r_state   <= S_FRAME;
                            end
                            CMD_TICK: begin
                                if (r_active) begin
                                    r_advance <= 1'b1;
                                    r_digit   <= '0;
                                    r_state   <= S_FRAME;
                                end
                            end
                            CMD_STOP:  r_active <= 1'b0;
                            default:   r_active <= r_active;
                        endcase
                    end
                end
                S_FRAME: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_digit   <= r_digit;
                        r_out_pattern <= glyph;
                        r_out_last    <= (r_digit == LAST_DIGIT);
                        if (r_digit == '0) begin
                            r_head_char <= ch;
                        end
                        if (r_digit == LAST_DIGIT) begin
                            if (r_advance) begin
                                r_pos <= n_pos;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_digit <= r_digit + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> design/scrolling_text_segment_driver_unit.sv
// -----------------------------------------------------------------------------
// scrolling_text_segment_driver_unit
// Five-digit 14-segment scrolling marquee with stream ports and register port.
// -----------------------------------------------------------------------------
// A start, or a tick while scrolling is on, is queued and popped into the frame state;
// the digit sequencer then sends its five digits through the registered output stage,
// stalling while held; clear, write and stop apply on pop; a two-entry queue holds requests.
// Reset: synchronous active low; text store reads blank, scroll position -1,
// scrolling off, top row font table selected.
`default_nettype none

module scrolling_text_segment_driver_unit
    import stsd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // char_index[4:0], char_code[12:5]
    input  wire logic [OP_W-1:0]        s_axis_tuser,   // op[2:0]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // digit[2:0], pattern[17:3]
    output logic                        m_axis_tlast,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]       prdata,
    output logic                        pready
);

    logic                  r_row_select;
    t_queue_head           head;
    logic                  pop;
    logic [DIGIT_W-1:0]    out_digit;
    logic [PATTERN_W-1:0]  out_pattern;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_ROW_SELECT) ? CFG_DATA_W'(r_row_select) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_select <= 1'b0;
        end else if (cfg_write && paddr[2] == REG_ROW_SELECT) begin
            r_row_select <= pwdata[0];
        end
    end

    stsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_index (s_axis_tdata[INDEX_W-1:0]),
        .i_code  (s_axis_tdata[INDEX_W+CODE_W-1:INDEX_W]),
        .o_head  (head),
        .i_pop   (pop)
    );

    stsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .i_row_select (r_row_select),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_digit      (out_digit),
        .o_pattern    (out_pattern),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_pattern, out_digit});

endmodule

`default_nettype wire

>>> design/stsd_checker.sv
// -----------------------------------------------------------------------------
// stsd_checker
// Port-level checks on the result stream, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stsd_checker
    import stsd_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tlast
);

    `ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_NEXT(a_data_held, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `ASSERT_IMPL(a_last_on_fifth, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[2:0] == LAST_DIGIT))
    `ASSERT_NEXT(a_digit_step, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !m_axis_tvalid || (m_axis_tdata[2:0] == $past(m_axis_tdata[2:0]) + 3'd1))
    `ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid || (m_axis_tdata[2:0] == 3'd0))

endmodule

bind scrolling_text_segment_driver_unit stsd_checker u_stsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> verif/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Stream-level test of the scrolling text segment driver: writes text, starts
// and ticks the marquee, switches the row font table over the register port,
// and checks every digit of every frame against a local marquee predictor.
// Both stream sides idle at random; one phase backs up the output on purpose.
// -----------------------------------------------------------------------------
module testbench;
    import stsd_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int MAX_GAP        = 17;
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 250;
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic [OP_W-1:0]       OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0]       OP_RESERVED_LAST  = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] ROW_SELECT_ADDR   = CFG_ADDR_W'(4 * REG_ROW_SELECT);

    localparam logic [PATTERN_W-1:0] TOP_LETTERS [28] = '{
        15'h4b19, 15'h5b42, 15'h0858, 15'h5a42, 15'h0859, 15'h0819, 15'h4958,
        15'h4319, 15'h1842, 15'h4250, 15'h2419, 15'h0058, 15'h461c, 15'h621c,
        15'h4a58, 15'h0b19, 15'h6a58, 15'h2b19, 15'h4949, 15'h1802, 15'h4258,
        15'h0438, 15'h6238, 15'h2424, 15'h1404, 15'h0c60, 15'h0101, 15'h0141
    };
    localparam logic [PATTERN_W-1:0] BOTTOM_LETTERS [28] = '{
        15'h4359, 15'h185b, 15'h4a40, 15'h185a, 15'h4b40, 15'h4340, 15'h4a49,
        15'h4319, 15'h1842, 15'h0a18, 15'h4324, 15'h4a00, 15'h6238, 15'h621c,
        15'h4a58, 15'h4351, 15'h4a5c, 15'h4355, 15'h4949, 15'h1042, 15'h4a18,
        15'h4620, 15'h461c, 15'h2424, 15'h2022, 15'h0c60, 15'h0101, 15'h0901
    };
    localparam logic [PATTERN_W-1:0] TOP_DIGITS [10] = '{
        15'h4a58, 15'h4200, 15'h0b51, 15'h4b41, 15'h4309, 15'h4949, 15'h4959,
        15'h4a00, 15'h4b59, 15'h4b49
    };
    localparam logic [PATTERN_W-1:0] BOTTOM_DIGITS [10] = '{
        15'h4a58, 15'h0018, 15'h0b51, 15'h0959, 15'h4119, 15'h4949, 15'h4b49,
        15'h0058, 15'h4b59, 15'h4959
    };

    typedef struct {
        logic [DIGIT_W-1:0]   digit;
        logic [PATTERN_W-1:0] pattern;
        logic                 last;
    } t_digit_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // char_index[4:0], char_code[12:5]
    logic [OP_W-1:0]        s_axis_tuser;   // op[2:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // digit[2:0], pattern[17:3]
    logic                   m_axis_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    logic [CODE_W-1:0]        shadow_text [TEXT_DEPTH];
    logic signed [POS_W-1:0]  shadow_pos;
    logic                     shadow_run;
    logic                     shadow_row;
    t_digit_result            digit_expect_q [$];

    int  mismatches;
    int  idle_cycles;
    int  rx_hold;
    bit  tx_fast;
    bit  rx_fast;

    scrolling_text_segment_driver_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [PATTERN_W-1:0] segment_glyph(input logic [CODE_W-1:0] ch,
                                                           input logic row);
        logic [PATTERN_W-1:0] g;
        g = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
            g = row ? BOTTOM_LETTERS[ch - CH_UPPER_A] : TOP_LETTERS[ch - CH_UPPER_A];
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            g = row ? BOTTOM_LETTERS[ch - CH_LOWER_A] : TOP_LETTERS[ch - CH_LOWER_A];
        else if (ch >= CH_ZERO && ch <= CH_NINE)
            g = row ? BOTTOM_DIGITS[ch - CH_ZERO] : TOP_DIGITS[ch - CH_ZERO];
        else if (ch == CH_EQUALS)
            g = row ? BOTTOM_LETTERS[GLYPH_EQUALS] : TOP_LETTERS[GLYPH_EQUALS];
        else if (ch == CH_MINUS)
            g = row ? BOTTOM_LETTERS[GLYPH_MINUS] : TOP_LETTERS[GLYPH_MINUS];
        return g;
    endfunction

    function automatic logic [CODE_W-1:0] text_at(input int p);
        if (p < 0 || p >= TEXT_DEPTH)
            return '0;
        return shadow_text[p];
    endfunction

    function automatic void push_frame();
        t_digit_result r;
        for (int d = 0; d < DIGITS; d++) begin
            r.digit   = DIGIT_W'(d);
            r.pattern = segment_glyph(text_at(int'(shadow_pos) + d), shadow_row);
            r.last    = (d == DIGITS - 1);
            digit_expect_q.push_back(r);
        end
    endfunction

    function automatic void predict_marquee(input logic [OP_W-1:0] op,
                                            input logic [INDEX_W-1:0] idx,
                                            input logic [CODE_W-1:0] code);
        int p;
        case (op)
            OP_CLEAR: begin
                for (int i = 0; i < TEXT_DEPTH; i++)
                    shadow_text[i] = '0;
            end
            OP_WRITE: begin
                if (int'(idx) < TEXT_DEPTH)
                    shadow_text[idx] = code;
            end
            OP_START: begin
                shadow_pos = POS_W'(-1);
                shadow_run = 1'b1;
                push_frame();
            end
            OP_TICK: begin
                if (shadow_run) begin
                    push_frame();
                    p = int'(shadow_pos);
                    if (p < 0)
                        shadow_pos = shadow_pos + POS_W'(1);
                    else if (p > TEXT_DEPTH - 1 || text_at(p) == '0)
                        shadow_pos = POS_W'(-4);
                    else
                        shadow_pos = shadow_pos + POS_W'(1);
                end
            end
            OP_STOP: shadow_run = 1'b0;
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected 0x%0h, got 0x%0h", what, want, got);
    endfunction

    function automatic void check_digit();
        t_digit_result want;
        if (digit_expect_q.size() == 0) begin
            note_mismatch("unexpected digit", 0, m_axis_tdata);
            return;
        end
        want = digit_expect_q.pop_front();
        if (m_axis_tdata[2:0] !== want.digit)
            note_mismatch("digit", want.digit, m_axis_tdata[2:0]);
        if (m_axis_tdata[17:3] !== want.pattern)
            note_mismatch("pattern", want.pattern, m_axis_tdata[17:3]);
        if (m_axis_tlast !== want.last)
            note_mismatch("last", want.last, m_axis_tlast);
    endfunction

    always @(posedge i_clk) begin : monitor
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_marquee(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[12:5]);
            if (m_axis_tvalid && m_axis_tready)
                check_digit();
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : digit_receiver
        int gap;
        forever begin
            if (rx_hold > 0) begin
                gap     = rx_hold;
                rx_hold = 0;
            end else begin
                gap = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && i_rst_n));
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic [CODE_W-1:0] code);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, code, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (digit_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_row_select(input logic row);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROW_SELECT_ADDR;
        pwdata  <= CFG_DATA_W'(row);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_row = row;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== CFG_DATA_W'(row))
            note_mismatch("row_select readback", row, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [CODE_W-1:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1, 2: return CH_UPPER_A + CODE_W'($urandom_range(0, 25));
            3, 4:    return CH_LOWER_A + CODE_W'($urandom_range(0, 25));
            5, 6:    return CH_ZERO + CODE_W'($urandom_range(0, 9));
            7:       return CH_MINUS;
            8:       return CH_EQUALS;
            default: return CODE_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic test_stopped_and_reserved();
        send_request(OP_TICK, '0, '0);
        send_request(OP_STOP, '0, '0);
        send_request(OP_RESERVED_FIRST, 5'h1f, 8'hff);
        send_request(OP_RESERVED_FIRST + 3'd1, '0, '0);
        send_request(OP_RESERVED_LAST, 5'h15, 8'haa);
        send_request(OP_START, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_STOP, '0, '0);
        send_request(OP_TICK, '0, '0);
    endtask

    task automatic test_glyph_table();
        send_request(OP_CLEAR, '0, '0);
        send_request(OP_WRITE, 5'd0, CH_UPPER_A);
        send_request(OP_WRITE, 5'd1, CH_LOWER_Z);
        send_request(OP_WRITE, 5'd2, CH_NINE);
        send_request(OP_WRITE, 5'd3, CH_MINUS);
        send_request(OP_WRITE, 5'd4, CH_EQUALS);
        send_request(OP_WRITE, 5'd5, 8'hff);
        send_request(OP_WRITE, 5'd6, CH_ZERO);
        send_request(OP_WRITE, 5'd31, CH_UPPER_Z);
        send_request(OP_START, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);
        set_row_select(1'b1);
        send_request(OP_START, '0, '0);
        send_request(OP_TICK, '0, '0);
        send_request(OP_TICK, '0, '0);
    endtask

    task automatic test_random_messages();
        int len;
        int ticks;
        logic [OP_W-1:0] noise;
        for (int round = 0; round < 5; round++) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            if (round == 0)
                set_row_select(1'b0);
            else if ($urandom_range(0, 1))
                set_row_select(1'($urandom_range(0, 1)));
            send_request(OP_CLEAR, '0, '0);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++)
                send_request(OP_WRITE, INDEX_W'(i), pick_char());
            send_request(OP_START, '0, '0);
            if (round == 0)
                wait_results_drained();
            ticks = $urandom_range(2, len + 5);
            for (int t = 0; t < ticks; t++) begin
                if ($urandom_range(0, 7) == 0) begin
                    case ($urandom_range(0, 3))
                        0: noise = OP_STOP;
                        1: noise = OP_CLEAR;
                        2: noise = OP_WRITE;
                        default: noise = OP_RESERVED_FIRST + OP_W'($urandom_range(0, 2));
                    endcase
                    send_request(noise, INDEX_W'($urandom_range(0, 31)),
                                 CODE_W'($urandom_range(0, 255)));
                    if (noise == OP_STOP && $urandom_range(0, 1))
                        send_request(OP_START, '0, '0);
                end
                send_request(OP_TICK, '0, '0);
            end
        end
        tx_fast = 1'b0;
        rx_fast = 1'b0;
    endtask

    task automatic test_full_store_wrap();
        set_row_select(1'b1);
        send_request(OP_CLEAR, '0, '0);
        for (int i = 0; i < TEXT_DEPTH; i++)
            send_request(OP_WRITE, INDEX_W'(i), pick_char());
        send_request(OP_START, '0, '0);
        tx_fast = 1'b1;
        rx_hold = LONG_HOLD;
        for (int t = 0; t < 12; t++)
            send_request(OP_TICK, '0, '0);
        tx_fast = 1'b0;
        for (int t = 12; t < 36; t++)
            send_request(OP_TICK, '0, '0);
        send_request(OP_STOP, '0, '0);
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_CLEAR;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        for (int i = 0; i < TEXT_DEPTH; i++)
            shadow_text[i] = '0;
        shadow_pos  = POS_W'(-1);
        shadow_run  = 1'b0;
        shadow_row  = 1'b0;
        mismatches  = 0;
        idle_cycles = 0;
        rx_hold     = 0;
        tx_fast     = 1'b0;
        rx_fast     = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stopped_and_reserved();
        test_glyph_table();
        test_random_messages();
        test_full_store_wrap();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (digit_expect_q.size() != 0)
            note_mismatch("digits still expected", 0, digit_expect_q.size());
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> scrolling_text_segment_driver_unit.f
+incdir+design
design/stsd_pkg.sv
design/stsd_front.sv
design/stsd_back.sv
design/scrolling_text_segment_driver_unit.sv
design/stsd_checker.sv
verif/testbench.sv
